@@ rtl/gbn_pkg.sv @@
// Shared types and constants of the go-back-N ARQ endpoint.
package gbn_pkg;

    localparam int SEQ_BITS    = 2;
    localparam int SEQ_SPACE   = 1 << SEQ_BITS;
    localparam int HANDLE_BITS = 16;
    localparam int AGE_BITS    = 24;
    localparam int CNT_BITS    = 3;

    localparam logic [AGE_BITS-1:0] AGE_MAX     = '1;
    localparam logic [AGE_BITS-1:0] LIMIT_RESET = 24'd8000000;

    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_SEND = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [1:0] ACT_DATA    = 2'd0;
    localparam logic [1:0] ACT_ACK     = 2'd1;
    localparam logic [1:0] ACT_DELIVER = 2'd2;
    localparam logic [1:0] ACT_REFUSED = 2'd3;

    typedef enum logic [1:0] {
        OP_ACK,
        OP_DATA,
        OP_SEND,
        OP_TICK
    } op_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic                   frame_is_ack;
        logic [SEQ_BITS-1:0]    frame_seq;
        logic [HANDLE_BITS-1:0] payload_handle;
    } in_word_t;

    typedef struct packed {
        logic [1:0]             action;
        logic [SEQ_BITS-1:0]    out_seq;
        logic [HANDLE_BITS-1:0] out_handle;
        logic [CNT_BITS-1:0]    outstanding;
        logic                   last;
    } out_word_t;

    typedef struct packed {
        logic                   valid;
        op_t                    op;
        logic [SEQ_BITS-1:0]    seq;
        logic [HANDLE_BITS-1:0] handle;
    } cmd_t;

endpackage

@@ rtl/gbn_front.sv @@
// Front end: accepts input words, classifies them and queues commands.
module gbn_front
    import gbn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_word_t in_word,
    output cmd_t     cmd,
    input  logic     pop
);

    cmd_t        q_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        keep;
    logic        push;
    logic        do_pop;
    op_t         op;

    always_comb
    begin
        keep = 1'b1;
        op   = OP_TICK;
        case (in_word.kind)
            KIND_RX:   op = in_word.frame_is_ack ? OP_ACK : OP_DATA;
            KIND_SEND: op = OP_SEND;
            KIND_TICK: op = OP_TICK;
            default:   keep = 1'b0;
        endcase
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall && keep;
    assign do_pop   = pop && (cnt_reg != 2'd0);

    always_comb
    begin
        cmd       = q_reg[rd_ptr_reg];
        cmd.valid = (cnt_reg != 2'd0);
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{valid:  1'b1,
                                   op:     op,
                                   seq:    in_word.frame_seq,
                                   handle: in_word.payload_handle};
        end
    end

endmodule

@@ rtl/gbn_back.sv @@
// Back end: window state, timers, retransmission sequencing and result register.
module gbn_back
    import gbn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output logic                pop,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [AGE_BITS-1:0] cfg_word,
    output logic                out_valid,
    input  logic                out_stall,
    output out_word_t           out_word
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACK,
        ST_RETX
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [SEQ_BITS-1:0]    next_send_reg;
    logic [SEQ_BITS-1:0]    next_send_next;
    logic [SEQ_BITS-1:0]    oldest_reg;
    logic [SEQ_BITS-1:0]    oldest_next;
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;
    logic [SEQ_BITS-1:0]    last_acc_reg;
    logic [SEQ_BITS-1:0]    last_acc_next;
    logic [SEQ_BITS-1:0]    ack_seq_reg;
    logic [SEQ_BITS-1:0]    ack_seq_next;
    logic [SEQ_BITS-1:0]    idx_reg;
    logic [SEQ_BITS-1:0]    idx_next;
    logic [AGE_BITS-1:0]    limit_reg;
    logic [AGE_BITS-1:0]    ages_reg  [SEQ_SPACE];
    logic [AGE_BITS-1:0]    ages_next [SEQ_SPACE];
    logic [AGE_BITS-1:0]    age_inc   [SEQ_SPACE];
    logic [HANDLE_BITS-1:0] handles   [SEQ_SPACE];
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_word_t              out_word_reg;

    logic                   out_free;
    logic                   emit;
    out_word_t              emit_word;
    logic                   hw_en;
    logic [SEQ_SPACE-1:0]   busy;
    logic                   expired;
    logic [SEQ_BITS-1:0]    d;
    logic [SEQ_BITS-1:0]    expect_seq;
    logic [SEQ_BITS-1:0]    retx_seq;
    logic [SEQ_BITS-1:0]    off;
    logic                   retx_last;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign cfg_ready = 1'b1;

    assign d          = cmd.seq - oldest_reg;
    assign expect_seq = last_acc_reg + 1'b1;
    assign retx_seq   = oldest_reg + idx_reg;
    assign retx_last  = ({1'b0, idx_reg} + 1'b1) == count_reg;

    always_comb
    begin
        expired = 1'b0;
        for (int s = 0; s < SEQ_SPACE; s++)
        begin
            off      = SEQ_BITS'(s) - oldest_reg;
            busy[s]  = {1'b0, off} < count_reg;
            age_inc[s] = (ages_reg[s] == AGE_MAX) ? ages_reg[s] : ages_reg[s] + 1'b1;
            if (busy[s] && (age_inc[s] > limit_reg))
            begin
                expired = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        next_send_next = next_send_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        last_acc_next  = last_acc_reg;
        ack_seq_next   = ack_seq_reg;
        idx_next       = idx_reg;
        ages_next      = ages_reg;
        pop            = 1'b0;
        emit           = 1'b0;
        hw_en          = 1'b0;
        emit_word      = '{action:      ACT_ACK,
                           out_seq:     cmd.seq,
                           out_handle:  '0,
                           outstanding: count_reg,
                           last:        1'b1};
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid && out_free)
                begin
                    pop = 1'b1;
                    case (cmd.op)
                        OP_ACK:
                        begin
                            if ({1'b0, d} < count_reg)
                            begin
                                oldest_next = cmd.seq + 1'b1;
                                count_next  = count_reg - ({1'b0, d} + 1'b1);
                            end
                        end
                        OP_DATA:
                        begin
                            if (cmd.seq == expect_seq)
                            begin
                                last_acc_next        = expect_seq;
                                ack_seq_next         = cmd.seq;
                                emit                 = 1'b1;
                                emit_word.action     = ACT_DELIVER;
                                emit_word.out_handle = cmd.handle;
                                emit_word.last       = 1'b0;
                                state_next           = ST_ACK;
                            end
                            else if (cmd.seq == last_acc_reg)
                            begin
                                emit = 1'b1;
                            end
                        end
                        OP_SEND:
                        begin
                            emit                 = 1'b1;
                            emit_word.out_handle = cmd.handle;
                            if (count_reg == CNT_BITS'(SEQ_SPACE))
                            begin
                                emit_word.action  = ACT_REFUSED;
                                emit_word.out_seq = '0;
                            end
                            else
                            begin
                                hw_en                    = 1'b1;
                                ages_next[next_send_reg] = '0;
                                count_next               = count_reg + 1'b1;
                                next_send_next           = next_send_reg + 1'b1;
                                emit_word.action         = ACT_DATA;
                                emit_word.out_seq        = next_send_reg;
                                emit_word.outstanding    = count_reg + 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            for (int s = 0; s < SEQ_SPACE; s++)
                            begin
                                if (busy[s])
                                begin
                                    ages_next[s] = expired ? '0 : age_inc[s];
                                end
                            end
                            if (expired)
                            begin
                                idx_next   = '0;
                                state_next = ST_RETX;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    emit_word.out_seq = ack_seq_reg;
                    state_next        = ST_IDLE;
                end
            end
            ST_RETX:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    emit_word.action     = ACT_DATA;
                    emit_word.out_seq    = retx_seq;
                    emit_word.out_handle = handles[retx_seq];
                    emit_word.last       = retx_last;
                    idx_next             = idx_reg + 1'b1;
                    if (retx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = emit ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            next_send_reg <= '0;
            oldest_reg    <= '0;
            count_reg     <= '0;
            last_acc_reg  <= SEQ_BITS'(SEQ_SPACE - 1);
            ack_seq_reg   <= '0;
            idx_reg       <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < SEQ_SPACE; s++)
            begin
                ages_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            next_send_reg <= next_send_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            last_acc_reg  <= last_acc_next;
            ack_seq_reg   <= ack_seq_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            ages_reg      <= ages_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_word;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            handles[next_send_reg] <= cmd.handle;
        end
        if (emit)
        begin
            out_word_reg <= emit_word;
        end
    end

endmodule

@@ rtl/go_back_n_arq_endpoint.sv @@
// Go-back-N ARQ endpoint top level: command queue front end and window back end.
//
// Input channel in_valid/in_stall/in_word carries one event per word: a received
// frame, a send request or a timer tick. Output channel out_valid/out_stall/out_word
// carries actions: transmit data, transmit ack, deliver upward or refuse a send;
// last marks the final action of one event. cfg_valid/cfg_ready/cfg_word writes
// the timeout limit in ticks; cfg_ready is always high. Write it only while idle.
// With the queue empty, an accepted event passes the command queue register and
// then the output register before its first action appears; a timeout resend
// also passes the retransmit state. An in-order data frame passes the idle and
// ack states; a timeout resends each outstanding frame from the retransmit state.
// A two-word command queue ahead of the back end absorbs bursts, and in_stall
// rises only when that queue is full.
// Reset clears the window to empty, all timers to zero, the expected receive
// sequence to zero and the timeout limit to 8000000 ticks.
// While out_stall is high the output word holds and the back end waits; the
// front end keeps accepting until its queue fills.
module go_back_n_arq_endpoint
    import gbn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_word_t            in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output out_word_t           out_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [AGE_BITS-1:0] cfg_word
);

    cmd_t cmd;
    logic pop;

    gbn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .cmd      (cmd),
        .pop      (pop)
    );

    gbn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .pop       (pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_word  (cfg_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

@@ test/tb_go_back_n_arq_endpoint.sv @@
`timescale 1ns / 1ps
// Testbench for the go-back-N ARQ endpoint: directed table, random traffic, action checking.
module tb_go_back_n_arq_endpoint;
    import gbn_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic                is_cfg;
        logic [AGE_BITS-1:0] cfg_value;
        in_word_t            word;
        logic                typed;
        logic [1:0]          n_typed;
        out_word_t           e0;
        out_word_t           e1;
    } step_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    in_word_t            in_word;
    logic                out_valid;
    logic                out_stall;
    out_word_t           out_word;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [AGE_BITS-1:0] cfg_word;

    logic [SEQ_BITS-1:0]    win_next_seq;
    logic [SEQ_BITS-1:0]    win_oldest;
    logic [CNT_BITS-1:0]    win_count;
    logic [SEQ_BITS-1:0]    rx_last_seq;
    logic [HANDLE_BITS-1:0] slot_handle [SEQ_SPACE];
    logic [AGE_BITS-1:0]    slot_age [SEQ_SPACE];
    logic [AGE_BITS-1:0]    timeout_ticks;

    out_word_t pending_actions [$];
    out_word_t fresh_actions [$];
    step_row_t script [$];
    int        mismatch_count = 0;
    int        burst_left = 0;
    int        stall_hold = 0;
    logic [7:0] stall_pattern = 8'h00;

    go_back_n_arq_endpoint dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_word  (cfg_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic in_word_t mk_in(logic [1:0] kind, logic is_ack,
                                       logic [SEQ_BITS-1:0] seq,
                                       logic [HANDLE_BITS-1:0] handle);
        in_word_t w;
        w.kind           = kind;
        w.frame_is_ack   = is_ack;
        w.frame_seq      = seq;
        w.payload_handle = handle;
        return w;
    endfunction

    function automatic out_word_t mk_act(logic [1:0] action, logic [SEQ_BITS-1:0] seq,
                                         logic [HANDLE_BITS-1:0] handle,
                                         logic [CNT_BITS-1:0] cnt, logic is_last);
        out_word_t a;
        a.action      = action;
        a.out_seq     = seq;
        a.out_handle  = handle;
        a.outstanding = cnt;
        a.last        = is_last;
        return a;
    endfunction

    task automatic add_event(input in_word_t w);
        step_row_t row;
        row = '0;
        row.word = w;
        script = {script, row};
    endtask

    task automatic add_typed(input in_word_t w, input logic [1:0] n,
                             input out_word_t e0, input out_word_t e1);
        step_row_t row;
        row = '0;
        row.word    = w;
        row.typed   = 1'b1;
        row.n_typed = n;
        row.e0      = e0;
        row.e1      = e1;
        script = {script, row};
    endtask

    task automatic add_limit(input logic [AGE_BITS-1:0] v);
        step_row_t row;
        row = '0;
        row.is_cfg    = 1'b1;
        row.cfg_value = v;
        script = {script, row};
    endtask

    task automatic predict_actions(input in_word_t w);
        logic [SEQ_BITS-1:0] d;
        logic [SEQ_BITS-1:0] s;
        logic [SEQ_BITS-1:0] want;
        logic                expired;
        int                  i;
        fresh_actions.delete();
        expired = 1'b0;
        case (w.kind)
            KIND_RX:
            begin
                if (w.frame_is_ack)
                begin
                    d = w.frame_seq - win_oldest;
                    if ({1'b0, d} < win_count)
                    begin
                        win_oldest = win_oldest + d + 2'd1;
                        win_count  = win_count - ({1'b0, d} + 3'd1);
                    end
                end
                else
                begin
                    want = rx_last_seq + 2'd1;
                    if (w.frame_seq == want)
                    begin
                        rx_last_seq = want;
                        fresh_actions = {fresh_actions,
                                         mk_act(ACT_DELIVER, w.frame_seq,
                                                w.payload_handle, win_count, 1'b0)};
                        fresh_actions = {fresh_actions,
                                         mk_act(ACT_ACK, w.frame_seq, '0,
                                                win_count, 1'b0)};
                    end
                    else if (w.frame_seq == rx_last_seq)
                        fresh_actions = {fresh_actions,
                                         mk_act(ACT_ACK, w.frame_seq, '0,
                                                win_count, 1'b0)};
                end
            end
            KIND_SEND:
            begin
                if (int'(win_count) >= SEQ_SPACE)
                    fresh_actions = {fresh_actions,
                                     mk_act(ACT_REFUSED, '0, w.payload_handle,
                                            win_count, 1'b0)};
                else
                begin
                    s = win_next_seq;
                    slot_handle[s] = w.payload_handle;
                    slot_age[s]    = '0;
                    win_count      = win_count + 3'd1;
                    win_next_seq   = s + 2'd1;
                    fresh_actions = {fresh_actions,
                                     mk_act(ACT_DATA, s, w.payload_handle,
                                            win_count, 1'b0)};
                end
            end
            KIND_TICK:
            begin
                for (i = 0; i < int'(win_count); i++)
                begin
                    s = win_oldest + i[SEQ_BITS-1:0];
                    if (slot_age[s] < AGE_MAX)
                        slot_age[s] = slot_age[s] + 24'd1;
                    if (slot_age[s] > timeout_ticks)
                        expired = 1'b1;
                end
                if (expired)
                begin
                    for (i = 0; i < int'(win_count); i++)
                    begin
                        s = win_oldest + i[SEQ_BITS-1:0];
                        slot_age[s] = '0;
                        fresh_actions = {fresh_actions,
                                         mk_act(ACT_DATA, s, slot_handle[s],
                                                win_count, 1'b0)};
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (fresh_actions.size() > 0)
            fresh_actions[fresh_actions.size()-1].last = 1'b1;
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic push_word(input step_row_t row);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap > 0)
                idle_sender(gap);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= row.word;
        do @(posedge clk); while (in_stall);
        predict_actions(row.word);
        if (row.typed)
        begin
            if (row.n_typed >= 2'd1)
                pending_actions = {pending_actions, row.e0};
            if (row.n_typed >= 2'd2)
                pending_actions = {pending_actions, row.e1};
        end
        else
            foreach (fresh_actions[j])
                pending_actions = {pending_actions, fresh_actions[j]};
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(input logic [AGE_BITS-1:0] v);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_word  <= v;
        do @(posedge clk); while (!cfg_ready);
        timeout_ticks = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_event(output in_word_t w, output logic counts);
        logic [31:0] rnd;
        int          r;
        int          q;
        rnd    = $urandom;
        w      = rnd[$bits(in_word_t)-1:0];
        counts = 1'b1;
        r      = $urandom_range(0, 99);
        if (r < 30)
            w.kind = KIND_SEND;
        else if (r < 50)
        begin
            w.kind         = KIND_RX;
            w.frame_is_ack = 1'b1;
            if (win_count != 0 && $urandom_range(0, 4) != 0)
            begin
                rnd         = $urandom_range(0, int'(win_count) - 1);
                w.frame_seq = win_oldest + rnd[SEQ_BITS-1:0];
            end
        end
        else if (r < 72)
        begin
            w.kind         = KIND_RX;
            w.frame_is_ack = 1'b0;
            q = $urandom_range(0, 9);
            if (q < 7)
                w.frame_seq = rx_last_seq + 2'd1;
            else if (q < 9)
                w.frame_seq = rx_last_seq;
        end
        else if (r < 96)
            w.kind = KIND_TICK;
        else
        begin
            w.kind = KIND_UNUSED;
            counts = 1'b0;
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_hold == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                stall_pattern = 8'h00;
            else
                stall_pattern = 8'($urandom) & 8'h7F;
            stall_hold = $urandom_range(32, 96);
        end
        else
            stall_hold--;
        out_stall <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
    end

    always @(posedge clk)
    begin : check_words
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_actions.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: action %0d seq %0d handle %h outstanding %0d last %0d",
                             out_word.action, out_word.out_seq, out_word.out_handle,
                             out_word.outstanding, out_word.last);
            end
            else
            begin
                want = pending_actions.pop_front();
                if (out_word.action !== want.action || out_word.out_seq !== want.out_seq ||
                    out_word.out_handle !== want.out_handle ||
                    out_word.outstanding !== want.outstanding || out_word.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %0d/%0d/%h/%0d/%0d got %0d/%0d/%h/%0d/%0d",
                                 want.action, want.out_seq, want.out_handle,
                                 want.outstanding, want.last, out_word.action,
                                 out_word.out_seq, out_word.out_handle,
                                 out_word.outstanding, out_word.last);
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("go_back_n_arq_endpoint test failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [AGE_BITS-1:0] phase_limit [4];
        step_row_t           row;
        in_word_t            w;
        logic                counts;
        int                  k;
        int                  p;
        int                  n;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_word  = '0;
        out_stall = 1'b0;

        win_next_seq  = '0;
        win_oldest    = '0;
        win_count     = '0;
        rx_last_seq   = 2'd3;
        timeout_ticks = LIMIT_RESET;
        for (k = 0; k < SEQ_SPACE; k++)
        begin
            slot_handle[k] = '0;
            slot_age[k]    = '0;
        end

        add_typed(mk_in(KIND_TICK, 1'b0, 2'd0, 16'h0000), 2'd0, '0, '0);
        add_typed(mk_in(KIND_RX, 1'b0, 2'd0, 16'hFFFF), 2'd2,
                  mk_act(ACT_DELIVER, 2'd0, 16'hFFFF, 3'd0, 1'b0),
                  mk_act(ACT_ACK, 2'd0, 16'h0000, 3'd0, 1'b1));
        add_typed(mk_in(KIND_RX, 1'b0, 2'd0, 16'h1234), 2'd1,
                  mk_act(ACT_ACK, 2'd0, 16'h0000, 3'd0, 1'b1), '0);
        add_typed(mk_in(KIND_RX, 1'b0, 2'd2, 16'hABCD), 2'd0, '0, '0);
        add_typed(mk_in(KIND_RX, 1'b1, 2'd1, 16'h0000), 2'd0, '0, '0);
        add_typed(mk_in(KIND_UNUSED, 1'b1, 2'd3, 16'hFFFF), 2'd0, '0, '0);
        add_typed(mk_in(KIND_SEND, 1'b1, 2'd3, 16'h0000), 2'd1,
                  mk_act(ACT_DATA, 2'd0, 16'h0000, 3'd1, 1'b1), '0);
        add_typed(mk_in(KIND_SEND, 1'b0, 2'd0, 16'hFFFF), 2'd1,
                  mk_act(ACT_DATA, 2'd1, 16'hFFFF, 3'd2, 1'b1), '0);
        add_typed(mk_in(KIND_SEND, 1'b0, 2'd1, 16'hA5A5), 2'd1,
                  mk_act(ACT_DATA, 2'd2, 16'hA5A5, 3'd3, 1'b1), '0);
        add_typed(mk_in(KIND_SEND, 1'b1, 2'd2, 16'h5A5A), 2'd1,
                  mk_act(ACT_DATA, 2'd3, 16'h5A5A, 3'd4, 1'b1), '0);
        add_typed(mk_in(KIND_SEND, 1'b0, 2'd0, 16'h0F0F), 2'd1,
                  mk_act(ACT_REFUSED, 2'd0, 16'h0F0F, 3'd4, 1'b1), '0);
        add_typed(mk_in(KIND_TICK, 1'b1, 2'd3, 16'hFFFF), 2'd0, '0, '0);
        add_typed(mk_in(KIND_RX, 1'b1, 2'd1, 16'hFFFF), 2'd0, '0, '0);
        add_typed(mk_in(KIND_RX, 1'b1, 2'd0, 16'h0000), 2'd0, '0, '0);
        add_typed(mk_in(KIND_SEND, 1'b0, 2'd0, 16'h1111), 2'd1,
                  mk_act(ACT_DATA, 2'd0, 16'h1111, 3'd3, 1'b1), '0);
        add_typed(mk_in(KIND_RX, 1'b0, 2'd1, 16'h0042), 2'd2,
                  mk_act(ACT_DELIVER, 2'd1, 16'h0042, 3'd3, 1'b0),
                  mk_act(ACT_ACK, 2'd1, 16'h0000, 3'd3, 1'b1));
        add_typed(mk_in(KIND_RX, 1'b0, 2'd3, 16'h7777), 2'd0, '0, '0);
        add_limit(24'd0);
        add_event(mk_in(KIND_TICK, 1'b0, 2'd0, 16'h0000));
        add_limit(24'd1);
        add_event(mk_in(KIND_TICK, 1'b0, 2'd0, 16'h0000));
        add_event(mk_in(KIND_TICK, 1'b0, 2'd0, 16'h0000));
        add_event(mk_in(KIND_RX, 1'b1, 2'd0, 16'h0000));
        add_event(mk_in(KIND_TICK, 1'b0, 2'd0, 16'h0000));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < script.size(); k++)
        begin
            if (script[k].is_cfg)
                write_limit(script[k].cfg_value);
            else
                push_word(script[k]);
        end

        phase_limit[0] = AGE_MAX;
        phase_limit[1] = 24'd2;
        phase_limit[2] = 24'd5;
        phase_limit[3] = 24'd1;
        for (p = 0; p < 4; p++)
        begin
            write_limit(phase_limit[p]);
            n = 0;
            while (n < 27)
            begin
                if (p == 1 && n == 16)
                    wait_idle();
                pick_event(w, counts);
                row = '0;
                row.word = w;
                push_word(row);
                if (counts)
                    n++;
            end
        end

        wait_idle();
        if (mismatch_count == 0 && pending_actions.size() == 0)
            $display("go_back_n_arq_endpoint test passed");
        else
            $display("go_back_n_arq_endpoint test failed");
        $finish;
    end

endmodule
